// ===== hw/rtl/tdsc_pkg.sv =====
// Shared types, widths and constants of the TDOA direction sector classifier.
// Used by every module of the block; has no dependencies.

package tdsc_pkg;

    localparam int NUM_PAIRS     = 6;
    localparam int NUM_MICS      = 4;
    localparam int NUM_SECTORS   = 8;

    localparam int DELAY_W       = 16;
    localparam int MIC_W         = 24;
    localparam int OFF_W         = 25;
    localparam int BASE_W        = 26;
    localparam int PROJ_W        = 26;
    localparam int PROD_W        = 42;
    localparam int MEAS_W        = 25;
    localparam int ERR_W         = 27;
    localparam int MAG_W         = 26;
    localparam int SQ_W          = 52;
    localparam int SUM_W         = 55;
    localparam int REGION_W      = 4;
    localparam int MDATA_W       = 8;
    localparam int SDATA_W       = NUM_PAIRS * DELAY_W;
    localparam int CFG_ADDR_W    = 4;
    localparam int RND_SHIFT     = 15;

    localparam int SETTLE_CYCLES = 4;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    localparam logic signed [15:0]        DIAG_Q15    = 16'sd23170;
    localparam logic signed [MEAS_W-1:0]  SOUND_SPEED = 25'sd343;
    localparam logic signed [PROD_W-1:0]  RND_HALF    = 42'sd16384;

    localparam logic [CFG_ADDR_W-1:0] REG_MIC_LF_X = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_LF_Y = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_RF_X = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_RF_Y = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_RB_X = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_RB_Y = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_LB_X = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_LB_Y = 4'd7;

    typedef logic [1:0] mic_idx_t;

    localparam mic_idx_t MIC_LF = 2'd0;
    localparam mic_idx_t MIC_RF = 2'd1;
    localparam mic_idx_t MIC_RB = 2'd2;
    localparam mic_idx_t MIC_LB = 2'd3;

    localparam mic_idx_t PAIR_A [NUM_PAIRS] = '{MIC_LF, MIC_LF, MIC_LF, MIC_RF, MIC_RF, MIC_LB};
    localparam mic_idx_t PAIR_B [NUM_PAIRS] = '{MIC_RF, MIC_LB, MIC_RB, MIC_LB, MIC_RB, MIC_RB};

    typedef enum logic [2:0] {
        SEC_E  = 3'd0,
        SEC_NE = 3'd1,
        SEC_N  = 3'd2,
        SEC_NW = 3'd3,
        SEC_W  = 3'd4,
        SEC_SW = 3'd5,
        SEC_S  = 3'd6,
        SEC_SE = 3'd7
    } sector_t;

    typedef logic signed [MIC_W-1:0]  mic_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic signed [MEAS_W-1:0] meas_t;
    typedef logic [SUM_W-1:0]         sum_t;

    typedef struct packed {
        meas_t [NUM_PAIRS-1:0] meas;
        sum_t                  best_err;
        sector_t               best_idx;
    } link_t;

endpackage

// ===== hw/rtl/tdsc_cell.sv =====
// One sector cell of the classifier chain: projection for its angle, error sum,
// running minimum. Depends on tdsc_pkg.

module tdsc_cell
    import tdsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  sector_t sector_i,
    input  off_t    off_x_i [NUM_PAIRS],
    input  off_t    off_y_i [NUM_PAIRS],
    input  logic    valid_i,
    input  link_t   link_i,
    output logic    valid_o,
    output link_t   link_o
);

    logic signed [BASE_W-1:0] base_next [NUM_PAIRS];
    logic signed [BASE_W-1:0] base_reg  [NUM_PAIRS];
    logic signed [PROD_W-1:0] prod_next [NUM_PAIRS];
    logic signed [PROD_W-1:0] prod_reg  [NUM_PAIRS];
    logic signed [PROD_W-1:0] rnd       [NUM_PAIRS];
    logic signed [PROJ_W-1:0] proj_next [NUM_PAIRS];
    logic signed [PROJ_W-1:0] proj_reg  [NUM_PAIRS];
    logic                     is_diag;

    logic signed [ERR_W-1:0]  err       [NUM_PAIRS];
    logic [MAG_W-1:0]         mag       [NUM_PAIRS];
    logic [SQ_W-1:0]          sq_next   [NUM_PAIRS];
    logic [SQ_W-1:0]          sq1_reg   [NUM_PAIRS];
    logic                     v1_reg;
    link_t                    link1_reg;

    sum_t                     sum_next;
    sum_t                     sum2_reg;
    logic                     v2_reg;
    link_t                    link2_reg;

    link_t                    link3_next;
    link_t                    link3_reg;
    logic                     v3_reg;

    always_comb begin
        is_diag = 1'b0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            case (sector_i)
                SEC_E: begin
                    base_next[i] = BASE_W'(off_x_i[i]);
                end
                SEC_NE: begin
                    base_next[i] = BASE_W'(off_x_i[i]) + BASE_W'(off_y_i[i]);
                    is_diag      = 1'b1;
                end
                SEC_N: begin
                    base_next[i] = BASE_W'(off_y_i[i]);
                end
                SEC_NW: begin
                    base_next[i] = BASE_W'(off_y_i[i]) - BASE_W'(off_x_i[i]);
                    is_diag      = 1'b1;
                end
                SEC_W: begin
                    base_next[i] = -BASE_W'(off_x_i[i]);
                end
                SEC_SW: begin
                    base_next[i] = -BASE_W'(off_x_i[i]) - BASE_W'(off_y_i[i]);
                    is_diag      = 1'b1;
                end
                SEC_S: begin
                    base_next[i] = -BASE_W'(off_y_i[i]);
                end
                SEC_SE: begin
                    base_next[i] = BASE_W'(off_x_i[i]) - BASE_W'(off_y_i[i]);
                    is_diag      = 1'b1;
                end
                default: begin
                    base_next[i] = '0;
                end
            endcase
            prod_next[i] = PROD_W'(base_reg[i]) * PROD_W'(DIAG_Q15);
            rnd[i]       = prod_reg[i] + RND_HALF;
            proj_next[i] = is_diag ? rnd[i][RND_SHIFT +: PROJ_W] : base_reg[i];
        end
    end

    // projection follows the configuration continuously
    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        prod_reg <= prod_next;
        proj_reg <= proj_next;
    end

    always_comb begin
        for (int i = 0; i < NUM_PAIRS; i++) begin
            err[i]     = ERR_W'($signed(link_i.meas[i])) - ERR_W'(proj_reg[i]);
            mag[i]     = err[i][ERR_W-1] ? MAG_W'(-err[i]) : MAG_W'(err[i]);
            sq_next[i] = SQ_W'(mag[i]) * SQ_W'(mag[i]);
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            sum_next = sum_next + SUM_W'(sq1_reg[i]);
        end
    end

    always_comb begin
        link3_next = link2_reg;
        if (sum2_reg < link2_reg.best_err) begin
            link3_next.best_err = sum2_reg;
            link3_next.best_idx = sector_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq1_reg   <= sq_next;
            link1_reg <= link_i;
            sum2_reg  <= sum_next;
            link2_reg <= link1_reg;
            link3_reg <= link3_next;
        end
    end

    assign valid_o = v3_reg;
    assign link_o  = link3_reg;

endmodule

// ===== hw/rtl/tdsc_out_buf.sv =====
// Result register with one skid entry; parts the chain from the result channel.
// Depends on tdsc_pkg.

module tdsc_out_buf
    import tdsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  logic [REGION_W-1:0] region_i,
    output logic               ready_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [REGION_W-1:0] out_data_reg;
    logic [REGION_W-1:0] out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [REGION_W-1:0] skid_data_reg;
    logic [REGION_W-1:0] skid_data_next;
    logic                take;

    assign take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push_i) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = region_i;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = region_i;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready_o  = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(MDATA_W - REGION_W)'(0), out_data_reg};

endmodule

// ===== hw/rtl/tdoa_direction_sector_classifier_top.sv =====
// Top level of the TDOA direction sector classifier: configuration registers,
// input stage, chain of eight sector cells and result buffer.
// Depends on tdsc_pkg, tdsc_cell and tdsc_out_buf.
//
// Usage:
//   Input channel s_*: one transaction carries six signed 16-bit pair delays in
//   microseconds. Result channel m_*: one transaction per input transaction
//   carries the best sector 1..8 (angle (region-1)*45 degrees), in order.
//   Configuration: cfg_wr_en writes cfg_wdata into microphone register
//   cfg_addr (0..7); other addresses are dropped. Write only while idle.
//   Throughput: one transaction per cycle unless stalled, set by the input
//   stage and the eight cells, each a three-stage pipeline. A result passes
//   the input register, the three registers of each cell and the result
//   register. The projection registers of the cells follow the microphone
//   registers through the offset, base and product registers; s_tready is
//   held low after reset and each configuration write by a settle counter.
//   Reset: aresetn (synchronous, active low) clears the microphone positions
//   to zero and empties the chain and the result buffer.
//   Stall: with m_tready low the result register holds and one more result
//   parks in a skid entry; then the whole chain and s_tready hold until taken.

module tdoa_direction_sector_classifier_top
    import tdsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // delay_lf_rf, delay_lf_lb, delay_lf_rb, delay_rf_lb, delay_rf_rb, delay_lb_rb
    input  logic [SDATA_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // region [3:0], zero [7:4]
    output logic [MDATA_W-1:0]    m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [MIC_W-1:0]      cfg_wdata
);

    mic_t                mic_x_reg [NUM_MICS];
    mic_t                mic_y_reg [NUM_MICS];
    off_t                off_x_reg [NUM_PAIRS];
    off_t                off_y_reg [NUM_PAIRS];
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    logic                en;
    logic                s_accept;
    link_t               link0_next;
    logic                valid0_reg;
    link_t               link0_reg;
    logic                valid_c [NUM_SECTORS+1];
    link_t               link_c  [NUM_SECTORS+1];
    logic [REGION_W-1:0] region;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < NUM_MICS; m++) begin
                mic_x_reg[m] <= '0;
                mic_y_reg[m] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIC_LF_X: mic_x_reg[MIC_LF] <= cfg_wdata;
                REG_MIC_LF_Y: mic_y_reg[MIC_LF] <= cfg_wdata;
                REG_MIC_RF_X: mic_x_reg[MIC_RF] <= cfg_wdata;
                REG_MIC_RF_Y: mic_y_reg[MIC_RF] <= cfg_wdata;
                REG_MIC_RB_X: mic_x_reg[MIC_RB] <= cfg_wdata;
                REG_MIC_RB_Y: mic_y_reg[MIC_RB] <= cfg_wdata;
                REG_MIC_LB_X: mic_x_reg[MIC_LB] <= cfg_wdata;
                REG_MIC_LB_Y: mic_y_reg[MIC_LB] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_PAIRS; i++) begin
            off_x_reg[i] <= OFF_W'(mic_x_reg[PAIR_A[i]]) - OFF_W'(mic_x_reg[PAIR_B[i]]);
            off_y_reg[i] <= OFF_W'(mic_y_reg[PAIR_A[i]]) - OFF_W'(mic_y_reg[PAIR_B[i]]);
        end
    end

    always_comb begin
        settle_next = settle_reg;
        if (cfg_wr_en) begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign s_tready = en && (settle_reg == '0);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_PAIRS; i++) begin
            link0_next.meas[i] = MEAS_W'($signed(s_tdata[i*DELAY_W +: DELAY_W])) * SOUND_SPEED;
        end
        link0_next.best_err = '1;
        link0_next.best_idx = SEC_E;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            link0_reg <= link0_next;
        end
    end

    assign valid_c[0] = valid0_reg;
    assign link_c[0]  = link0_reg;

    for (genvar k = 0; k < NUM_SECTORS; k++) begin : g_cell
        tdsc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .sector_i (sector_t'(3'(k))),
            .off_x_i  (off_x_reg),
            .off_y_i  (off_y_reg),
            .valid_i  (valid_c[k]),
            .link_i   (link_c[k]),
            .valid_o  (valid_c[k+1]),
            .link_o   (link_c[k+1])
        );
    end

    assign region = REGION_W'(link_c[NUM_SECTORS].best_idx) + REGION_W'(1);

    tdsc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (en && valid_c[NUM_SECTORS]),
        .region_i (region),
        .ready_o  (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hw/rtl/tdsc_checker.sv =====
// Port-level checks of the classifier top level, bound to it below.
// Depends on tdsc_pkg and tdoa_direction_sector_classifier_top.

module tdsc_checker
    import tdsc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MDATA_W-1:0] m_tdata,
    input logic               cfg_wr_en
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_region_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'd8)
                     && (m_tdata[7:4] == 4'd0))
        else $error("region out of range");

    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted before projections settled");

endmodule

bind tdoa_direction_sector_classifier_top tdsc_checker u_tdsc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en)
);
